// ===== rtl/sse_pkg.sv =====
// Shared types and constants for the segment squared error cost block.
// No dependencies; imported by every module of the block.
package sse_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int COLUMNS     = 4;
    localparam int IN_COLUMNS  = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;

    localparam int ROW_W   = 11;
    localparam int COL_W   = 2;
    localparam int ADDR_W  = $clog2((MAX_ROWS + 1) * COLUMNS);
    localparam int SUM_W   = 26;
    localparam int SQ_W    = 41;
    localparam int MAG_W   = 26;
    localparam int SACC_W  = 43;
    localparam int QACC_W  = 53;
    localparam int DVD_W   = QACC_W + FRAC_BITS;
    localparam int COST_W  = 51;
    localparam int CNT_W   = $clog2(DVD_W + 1);

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
    } entry_t;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [ROW_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DVD_W-1:0]   quotient;
        logic               rem_nz;
    } div_rsp_t;

endpackage

// ===== rtl/segment_squared_error_cost_top.sv =====
// Top level of the segment squared error cost block: APB register,
// sequencer, prefix table and serial divider. Depends on sse_pkg,
// sse_mem and sse_div.
//
// Usage:
//  Input word (in_valid/in_ready): mode, four samples, seg_start, seg_end.
//  Mode 0 appends a row and updates per-column prefix sums and squares,
//  mode 1 returns the squared error of rows [seg_start, seg_end) about
//  their mean over the columns in use, mode 2 clears the row count.
//  Output word (out_valid/out_ready): cost (8 fraction bits), status,
//  rows_stored after the step.
//  Steps: an append does a table read, then a write, for each column.
//  A query does two table reads, subtract, then square and accumulate
//  for each column in use, then runs the bit-serial divider. Clear,
//  unused mode and errors go straight to the output step.
//  One word is in progress at a time; in_ready is high whenever the
//  sequencer is idle, even while a result waits in the output register.
//  If the receiver stalls, the finished result waits until the output
//  register is free.
//  Reset clears row count, columns_in_use (to 4) and the handshakes;
//  table contents are undefined except row zero, which reads as zero.
module segment_squared_error_cost_top
    import sse_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [1:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input word
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              mode,
    input  logic signed [15:0]      sample_0,
    input  logic signed [15:0]      sample_1,
    input  logic signed [15:0]      sample_2,
    input  logic signed [15:0]      sample_3,
    input  logic [ROW_W-1:0]        seg_start,
    input  logic [ROW_W-1:0]        seg_end,
    // output word
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COST_W-1:0]       cost,
    output logic [1:0]              status,
    output logic [ROW_W-1:0]        rows_stored
);

    typedef enum logic [3:0] {
        S_IDLE, S_APP_RD, S_APP_WR, S_Q_RDH, S_Q_RDL, S_Q_ACC, S_Q_MUL,
        S_Q_DIV, S_FINISH
    } state_t;

    state_t                 state_reg;
    logic [2:0]             cols_reg;
    logic [ROW_W-1:0]       row_count_reg;
    logic [COL_W-1:0]       col_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg [COLUMNS];
    logic [30:0]            sqr_reg;
    logic [ROW_W-1:0]       start_reg;
    logic [ROW_W-1:0]       end_reg;
    entry_t                 hi_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic [SACC_W-1:0]      sacc_reg;
    logic [QACC_W-1:0]      qacc_reg;
    status_t                st_reg;
    logic [COST_W-1:0]      cost_res_reg;
    logic                   out_valid_reg;
    logic [COST_W-1:0]      cost_reg;
    status_t                status_reg;
    logic [ROW_W-1:0]       rows_reg;

    logic [2:0]             used;
    logic                   cfg_wr;
    logic                   accept;

    // table port signals
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    entry_t                 mem_wdata;
    logic [ROW_W-1:0]       rd_row;
    logic [ADDR_W-1:0]      mem_raddr;
    entry_t                 mem_rdata;

    div_req_t               dreq;
    div_rsp_t               drsp;

    logic signed [SUM_W-1:0] ds;
    logic [COST_W-1:0]      s_scaled;
    logic signed [SAMPLE_BITS-1:0] in_samp [IN_COLUMNS];

    // ---- configuration register ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cols_reg <= 3'd4;
        else if (cfg_wr && paddr == 2'd0)
            cols_reg <= pwdata[2:0];
    end

    assign prdata = (paddr == 2'd0) ? {29'd0, cols_reg} : 32'd0;

    // 0 counts as one column, anything above COLUMNS as COLUMNS
    assign used = (cols_reg == 3'd0) ? 3'd1 :
                  (cols_reg > 3'(COLUMNS)) ? 3'(COLUMNS) : cols_reg;

    assign in_samp[0] = sample_0;
    assign in_samp[1] = sample_1;
    assign in_samp[2] = sample_2;
    assign in_samp[3] = sample_3;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // ---- table access ----
    always_comb
    begin
        case (state_reg)
            S_APP_RD: rd_row = row_count_reg;
            S_Q_RDH:  rd_row = end_reg;
            default:  rd_row = start_reg;
        endcase
    end

    assign mem_raddr = ADDR_W'(rd_row * COLUMNS) + ADDR_W'(col_reg);
    assign mem_we    = (state_reg == S_APP_WR);
    assign mem_waddr = ADDR_W'((row_count_reg + 1'b1) * COLUMNS) + ADDR_W'(col_reg);
    assign mem_wdata.sum = mem_rdata.sum + SUM_W'(samp_reg[col_reg]);
    assign mem_wdata.sq  = mem_rdata.sq + SQ_W'(sqr_reg);

    sse_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rzero (rd_row == '0),
        .rdata (mem_rdata)
    );

    assign dreq.start    = (state_reg == S_Q_MUL) && ({1'b0, col_reg} + 3'd1 == used);
    assign dreq.dividend = {qacc_reg + QACC_W'(mag_reg * mag_reg), FRAC_BITS'(0)};
    assign dreq.divisor  = end_reg - start_reg;

    sse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign ds       = hi_reg.sum - mem_rdata.sum;
    assign s_scaled = {sacc_reg[COST_W-FRAC_BITS-1:0], FRAC_BITS'(0)};

    // ---- sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_count_reg <= '0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
        end
        else
        begin
            // output register loads in S_FINISH, empties on handshake
            if (state_reg == S_FINISH && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    col_reg      <= '0;
                    sacc_reg     <= '0;
                    qacc_reg     <= '0;
                    cost_res_reg <= '0;
                    st_reg       <= ST_OK;
                    start_reg    <= seg_start;
                    end_reg      <= seg_end;
                    for (int i = 0; i < COLUMNS; i++)
                    begin
                        samp_reg[i] <= (i < IN_COLUMNS) ? in_samp[i] : '0;
                    end
                    if (accept)
                    begin
                        case (mode)
                            MODE_APPEND:
                            begin
                                if (row_count_reg >= ROW_W'(MAX_ROWS))
                                begin
                                    st_reg    <= ST_FULL;
                                    state_reg <= S_FINISH;
                                end
                                else
                                    state_reg <= S_APP_RD;
                            end
                            MODE_QUERY:
                            begin
                                if (seg_start >= seg_end || seg_end > row_count_reg)
                                begin
                                    st_reg    <= ST_RANGE;
                                    state_reg <= S_FINISH;
                                end
                                else
                                    state_reg <= S_Q_RDH;
                            end
                            MODE_CLEAR:
                            begin
                                row_count_reg <= '0;
                                state_reg     <= S_FINISH;
                            end
                            default: state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_APP_RD:
                begin
                    sqr_reg   <= 31'(samp_reg[col_reg] * samp_reg[col_reg]);
                    state_reg <= S_APP_WR;
                end
                S_APP_WR:
                begin
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        row_count_reg <= row_count_reg + 1'b1;
                        state_reg     <= S_FINISH;
                    end
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= S_APP_RD;
                    end
                end
                S_Q_RDH: state_reg <= S_Q_RDL;
                S_Q_RDL:
                begin
                    hi_reg    <= mem_rdata;
                    state_reg <= S_Q_ACC;
                end
                S_Q_ACC:
                begin
                    mag_reg   <= ds[SUM_W-1] ? MAG_W'(-ds) : MAG_W'(ds);
                    sacc_reg  <= sacc_reg + SACC_W'(hi_reg.sq - mem_rdata.sq);
                    state_reg <= S_Q_MUL;
                end
                S_Q_MUL:
                begin
                    qacc_reg <= qacc_reg + QACC_W'(mag_reg * mag_reg);
                    if (dreq.start)
                        state_reg <= S_Q_DIV;
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= S_Q_RDH;
                    end
                end
                S_Q_DIV:
                begin
                    if (drsp.done)
                    begin
                        // S*2^F - ceil(Q*2^F/n); exact value fits the cost width
                        cost_res_reg <= s_scaled - drsp.quotient[COST_W-1:0]
                                        - COST_W'(drsp.rem_nz);
                        state_reg    <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        cost_reg      <= cost_res_reg;
                        status_reg    <= st_reg;
                        rows_reg      <= row_count_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign cost        = cost_reg;
    assign status      = status_reg;
    assign rows_stored = rows_reg;

    // ---- checks ----
    a_err_zero_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> cost == '0)
        else $error("nonzero cost with error status");

    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= ROW_W'(MAX_ROWS))
        else $error("row count above table size");

    a_div_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == S_Q_DIV)
        else $error("divider finished outside query");

endmodule

// ===== rtl/sse_mem.sv =====
// Prefix table: one write port, one registered read port.
// Depends on sse_pkg; row zero reads as zero through the rzero flag.
module sse_mem
    import sse_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic [ADDR_W-1:0] raddr,
    input  logic              rzero,
    output entry_t            rdata
);

    entry_t mem [(MAX_ROWS + 1) * COLUMNS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rzero)
            rdata_reg <= '0;
        else
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sse_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sse_pkg for request and response types.
module sse_div
    import sse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DVD_W-1:0] q_reg;
    logic [ROW_W:0]   rem_reg;
    logic [ROW_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [ROW_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[ROW_W-1:0], q_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= req.dividend;
                rem_reg  <= '0;
                d_reg    <= req.divisor;
            end
            else if (busy_reg)
            begin
                q_reg   <= {q_reg[DVD_W-2:0], fits};
                rem_reg <= fits ? rem_sh - {1'b0, d_reg} : rem_sh;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;
    assign rsp.rem_nz   = rem_reg != '0;

endmodule

// ===== verif/tb_segment_squared_error_cost_top.sv =====
// Testbench for segment_squared_error_cost_top: drives rows and queries,
// predicts each result in a local prefix-table model and checks it.
// Depends on sse_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_segment_squared_error_cost_top;
    import sse_pkg::*;

    localparam logic [1:0] REG_COLUMNS_IN_USE = 2'd0;
    localparam int         DRAIN_CYCLES       = 100;   // wait after the last result
    localparam int         LONG_HOLD          = 400;

    typedef struct {
        logic [COST_W-1:0] cost;
        status_t           status;
        logic [ROW_W-1:0]  rows;
    } seg_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_ready;
    logic [1:0] mode;
    logic signed [15:0] sample_0, sample_1, sample_2, sample_3;
    logic [ROW_W-1:0] seg_start, seg_end;
    logic out_valid, out_ready;
    logic [COST_W-1:0] cost;
    logic [1:0] status;
    logic [ROW_W-1:0] rows_stored;

    // expected results, oldest first
    seg_result_t expected_costs[$];
    int fail_count = 0;

    // idling controls, percent of cycles
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit long_hold_req = 0;

    // local copy of block state
    int unsigned      cols_setting;
    int unsigned      row_total;
    longint           sum_table[0:(MAX_ROWS + 1) * COLUMNS - 1];
    longint           square_table[0:(MAX_ROWS + 1) * COLUMNS - 1];

    segment_squared_error_cost_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2),
        .sample_3(sample_3), .seg_start(seg_start), .seg_end(seg_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .cost(cost), .status(status), .rows_stored(rows_stored)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off on request so the
    // block fills up and drops in_ready.
    always @(posedge clk)
    begin
        int hold_left;
        if (long_hold_req)
        begin
            long_hold_req = 0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Result checker: every accepted output word against the oldest expectation.
    always @(posedge clk)
    begin
        seg_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_costs.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected word cost=%0d status=%0d rows=%0d",
                         $time, cost, status, rows_stored);
            end
            else
            begin
                want = expected_costs.pop_front();
                if (cost !== want.cost)
                begin
                    fail_count++;
                    $display("%0t: cost expected %0d actual %0d", $time, want.cost, cost);
                end
                if (status !== want.status)
                begin
                    fail_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                end
                if (rows_stored !== want.rows)
                begin
                    fail_count++;
                    $display("%0t: rows_stored expected %0d actual %0d",
                             $time, want.rows, rows_stored);
                end
            end
        end
    end

    // Predict the result of one accepted word and update the local state.
    function automatic seg_result_t segment_cost_predict(
        mode_t m, logic signed [15:0] s0, logic signed [15:0] s1,
        logic signed [15:0] s2, logic signed [15:0] s3,
        logic [ROW_W-1:0] first, logic [ROW_W-1:0] last);
        seg_result_t r;
        longint smp[4];
        int unsigned used, n, prev, next;
        longint diff;
        longint unsigned sq_total, norm_total, mag, scaled, rounded_up;
        r.cost = '0;
        r.status = ST_OK;
        smp[0] = s0; smp[1] = s1; smp[2] = s2; smp[3] = s3;
        case (m)
            MODE_APPEND:
                if (row_total >= MAX_ROWS)
                    r.status = ST_FULL;
                else
                begin
                    prev = row_total * COLUMNS;
                    next = prev + COLUMNS;
                    for (int c = 0; c < COLUMNS; c++)
                    begin
                        sum_table[next + c] = sum_table[prev + c] + smp[c];
                        square_table[next + c] = square_table[prev + c] + smp[c] * smp[c];
                    end
                    row_total++;
                end
            MODE_QUERY:
                if (first >= last || last > row_total)
                    r.status = ST_RANGE;
                else
                begin
                    n = last - first;
                    used = (cols_setting == 0) ? 1 :
                           (cols_setting > COLUMNS) ? COLUMNS : cols_setting;
                    sq_total = 0;
                    norm_total = 0;
                    for (int c = 0; c < used; c++)
                    begin
                        diff = sum_table[last * COLUMNS + c] - sum_table[first * COLUMNS + c];
                        mag = (diff < 0) ? -diff : diff;
                        sq_total += square_table[last * COLUMNS + c]
                                    - square_table[first * COLUMNS + c];
                        norm_total += mag * mag;
                    end
                    // floor(S - Q/n) scaled, done as S*2^F - ceil(Q*2^F/n)
                    scaled = norm_total << FRAC_BITS;
                    rounded_up = scaled / n + ((scaled % n) != 0);
                    r.cost = COST_W'((sq_total << FRAC_BITS) - rounded_up);
                end
            MODE_CLEAR:
                row_total = 0;
            default: ;
        endcase
        r.rows = ROW_W'(row_total);
        return r;
    endfunction

    // Offer one input word; called at a rising edge, returns at the
    // edge where it was accepted. Valid is left high for a following word.
    task automatic send_word(mode_t m, logic signed [15:0] s0, logic signed [15:0] s1,
                             logic signed [15:0] s2, logic signed [15:0] s3,
                             logic [ROW_W-1:0] first, logic [ROW_W-1:0] last);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        mode <= m;
        sample_0 <= s0; sample_1 <= s1; sample_2 <= s2; sample_3 <= s3;
        seg_start <= first;
        seg_end <= last;
        do
            @(posedge clk);
        while (!in_ready);
        expected_costs.push_back(segment_cost_predict(m, s0, s1, s2, s3, first, last));
    endtask

    // Drop valid, wait for every result and let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_costs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_columns(int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_COLUMNS_IN_USE;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cols_setting = value & 7;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic [ROW_W-1:0] rnd_row();
        return ROW_W'($urandom);
    endfunction

    // One random word: mostly appends and well-formed queries.
    task automatic send_random_word();
        int unsigned pick, first, last;
        pick = $urandom_range(99);
        if (pick < 55)
            send_word(MODE_APPEND, pick_sample(), pick_sample(), pick_sample(),
                      pick_sample(), rnd_row(), rnd_row());
        else if (pick < 88 && row_total > 0)
        begin
            first = $urandom_range(row_total - 1);
            // short segments are the common case; others may run up to the last row
            if ($urandom_range(3) == 0)
                last = first + 1 + $urandom_range(row_total - first - 1);
            else
                last = first + 1 + $urandom_range((row_total - first - 1) % 16);
            send_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), rnd16(),
                      ROW_W'(first), ROW_W'(last));
        end
        else if (pick < 94)
            send_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), rnd16(),
                      rnd_row(), rnd_row());
        else if (pick < 97)
            send_word(MODE_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(),
                      rnd_row(), rnd_row());
        else
            send_word(MODE_NONE, rnd16(), rnd16(), rnd16(), rnd16(),
                      rnd_row(), rnd_row());
    endtask

    // Extremes of every field, each mode and each range error.
    task automatic test_directed();
        send_word(MODE_QUERY, 0, 0, 0, 0, 0, 1);            // empty table
        send_word(MODE_NONE, -1, -1, -1, -1, 11'h7ff, 11'h7ff);
        send_word(MODE_APPEND, 16'sh8000, 16'sh7fff, 0, -1, 0, 0);
        send_word(MODE_APPEND, 16'sh7fff, 16'sh8000, -1, 0, 0, 0);
        send_word(MODE_APPEND, 16'sh5555, 16'shaaaa, 16'sh0f0f, 16'shf0f0, 0, 0);
        send_word(MODE_QUERY, 0, 0, 0, 0, 0, 1);            // single row
        send_word(MODE_QUERY, 0, 0, 0, 0, 0, 3);
        send_word(MODE_QUERY, 0, 0, 0, 0, 1, 3);
        send_word(MODE_QUERY, 0, 0, 0, 0, 2, 2);            // empty segment
        send_word(MODE_QUERY, 0, 0, 0, 0, 3, 1);            // start after end
        send_word(MODE_QUERY, 0, 0, 0, 0, 0, 4);            // past row count
        send_word(MODE_QUERY, 0, 0, 0, 0, 11'h7ff, 11'h7ff);
        send_word(MODE_QUERY, 0, 0, 0, 0, 11'h400, 11'h7ff);
        send_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0);
        send_word(MODE_QUERY, 0, 0, 0, 0, 0, 1);            // cleared
        send_word(MODE_APPEND, 100, -200, 300, -400, 0, 0);
        send_word(MODE_QUERY, 0, 0, 0, 0, 0, 1);
        wait_idle();
    endtask

    // Every columns_in_use value, extremes included, with queries on each.
    task automatic test_columns();
        int unsigned settings[8] = '{0, 1, 7, 2, 3, 5, 6, 4};
        foreach (settings[i])
        begin
            write_columns(settings[i]);
            repeat (12) send_random_word();
            wait_idle();
        end
    endtask

    // Fill the table to the top, then append once more and query the whole.
    task automatic test_full_table();
        write_columns(COLUMNS);
        send_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            if (i % 2 == 0)
                send_word(MODE_APPEND, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 0, 0);
            else
                send_word(MODE_APPEND, 16'sh7fff, pick_sample(), 16'sh8000,
                          16'sh8000, 0, 0);
        end
        send_word(MODE_APPEND, 1, 2, 3, 4, 0, 0);
        send_word(MODE_QUERY, 0, 0, 0, 0, 0, ROW_W'(MAX_ROWS));
        send_word(MODE_QUERY, 0, 0, 0, 0, ROW_W'(MAX_ROWS - 1), ROW_W'(MAX_ROWS));
        send_word(MODE_QUERY, 0, 0, 0, 0, 1, ROW_W'(MAX_ROWS));
        send_word(MODE_QUERY, 0, 0, 0, 0, 0, ROW_W'(MAX_ROWS + 1));
        send_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0);
        wait_idle();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_random_word();
        wait_idle();
    endtask

    // Long receiver hold-off while words keep coming.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        long_hold_req = 1;
        repeat (30) send_random_word();
        wait_idle();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; mode = MODE_APPEND;
        sample_0 = '0; sample_1 = '0; sample_2 = '0; sample_3 = '0;
        seg_start = '0; seg_end = '0;
        out_ready = 1'b0;
        cols_setting = 4;
        row_total = 0;
        foreach (sum_table[i])
        begin
            sum_table[i] = 0;
            square_table[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_columns();
        test_full_table();
        test_random(80, 0, 0);
        test_random(70, 83, 0);
        write_columns(2);
        test_random(70, 0, 83);
        write_columns(4);
        test_random(70, 24, 24);
        test_backpressure();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sse_pkg.sv
rtl/sse_mem.sv
rtl/sse_div.sv
rtl/segment_squared_error_cost_top.sv
verif/tb_segment_squared_error_cost_top.sv
